// File: rtl/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared types and constants for the LFU cache table: the stored entry
// layout, operation codes, use-count limit and stream payload widths.
// ----------------------------------------------------------------------------
package lfu_pkg;

    localparam int KEY_W    = 32;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 16;
    localparam int STAMP_W  = 32;
    localparam int CAP_W    = 5;

    // Input tdata: key, value. Output tdata: hit, read_value, evicted, evicted_key.
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 72;

    localparam logic [CAP_W-1:0]   CAP_RESET = CAP_W'(16);
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic
    {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } op_t;

    // One stored entry, written and read as a whole word
    typedef struct packed
    {
        logic [STAMP_W-1:0] stamp;
        logic [COUNT_W-1:0] use_count;
        logic [VALUE_W-1:0] value;
        logic [KEY_W-1:0]   key;
    } entry_t;

endpackage

// File: rtl/lfu_cache_table_core.sv
// Sequence: an accepted transaction scans the filled entries, then decides
//   and pushes its result; a new input is accepted only once back in idle.
// Scan: one entry per cycle over the occupied slots; the push waits while
//   the output is not free.
// Reset: store empty (occupancy zero), stamp counter zero, capacity 16; no
//   memory clearing pass, entries beyond the occupancy are never read.
// ----------------------------------------------------------------------------
// lfu_cache_table_core
// Fully associative key/value store with least-frequently-used replacement.
// A sequencer scans the filled entries through a shared compare unit, then
// writes back at most one entry and presents one result.
// ----------------------------------------------------------------------------
module lfu_cache_table_core #(
    parameter int ENTRIES = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lfu_pkg::S_TDATA_W-1:0]   s_tdata,  // key[31:0], value[63:32]
    input  logic                            s_tuser,  // op[0]
    // Output stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lfu_pkg::M_TDATA_W-1:0]   m_tdata,  // hit[0], read_value[32:1],
                                                      // evicted[33],
                                                      // evicted_key[65:34], zero[71:66]
    // Capacity register write
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lfu_pkg::CAP_W-1:0]       cfg_data
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (OCC_W > lfu_pkg::CAP_W) ? OCC_W : lfu_pkg::CAP_W;
    localparam int PAD_W = lfu_pkg::M_TDATA_W - (2 + lfu_pkg::VALUE_W + lfu_pkg::KEY_W);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_PUSH
    } state_t;

    state_t                         state_reg;
    logic [lfu_pkg::CAP_W-1:0]      capacity_reg;
    logic [OCC_W-1:0]               occupancy_reg;
    logic [OCC_W-1:0]               occupancy_next;
    logic [lfu_pkg::STAMP_W-1:0]    stamp_reg;
    logic [lfu_pkg::STAMP_W-1:0]    stamp_inc;
    logic [OCC_W-1:0]               issue_cnt_reg;
    logic                           pend_reg;
    logic [IDX_W-1:0]               pend_idx_reg;
    lfu_pkg::op_t                   op_reg;
    logic [lfu_pkg::KEY_W-1:0]      key_reg;
    logic [lfu_pkg::VALUE_W-1:0]    value_reg;
    logic                           res_hit_reg;
    logic [lfu_pkg::VALUE_W-1:0]    res_rd_reg;
    logic                           res_ev_reg;
    logic [lfu_pkg::KEY_W-1:0]      res_evk_reg;
    logic                           m_tvalid_reg;
    logic [lfu_pkg::M_TDATA_W-1:0]  m_tdata_reg;

    logic                           s_accept;
    logic                           rd_en;
    lfu_pkg::entry_t                rd_data;
    logic                           match_found;
    logic [IDX_W-1:0]               match_idx;
    lfu_pkg::entry_t                match_entry;
    logic [IDX_W-1:0]               victim_idx;
    logic [lfu_pkg::KEY_W-1:0]      victim_key;
    logic [CMP_W-1:0]               cap_eff;
    logic                           wr_en;
    logic [IDX_W-1:0]               wr_addr;
    lfu_pkg::entry_t                wr_data;
    logic [lfu_pkg::COUNT_W-1:0]    count_up;
    logic                           dec_hit;
    logic [lfu_pkg::VALUE_W-1:0]    dec_rd;
    logic                           dec_ev;
    logic [lfu_pkg::KEY_W-1:0]      dec_evk;
    logic                           out_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign out_free  = !m_tvalid_reg || m_tready;

    // Issue one read per cycle over the filled slots
    assign rd_en     = (state_reg == ST_SCAN) && (issue_cnt_reg < occupancy_reg);
    assign stamp_inc = stamp_reg + lfu_pkg::STAMP_W'(1);

    lfu_entry_ram #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (issue_cnt_reg[IDX_W-1:0]),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    lfu_scan_unit #(
        .IDX_W (IDX_W)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear       (s_accept),
        .entry_vld   (pend_reg),
        .entry_idx   (pend_idx_reg),
        .entry       (rd_data),
        .key         (key_reg),
        .match_found (match_found),
        .match_idx   (match_idx),
        .match_entry (match_entry),
        .victim_idx  (victim_idx),
        .victim_key  (victim_key)
    );

    // Decide the write-back and the result from the scan outcome
    always_comb
    begin
        cap_eff = (CMP_W'(capacity_reg) > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES)
                                                          : CMP_W'(capacity_reg);
        count_up = (match_entry.use_count == lfu_pkg::COUNT_MAX)
                 ? match_entry.use_count
                 : match_entry.use_count + lfu_pkg::COUNT_W'(1);

        wr_en          = 1'b0;
        wr_addr        = match_idx;
        wr_data        = match_entry;
        occupancy_next = occupancy_reg;
        dec_hit        = match_found;
        dec_rd         = '0;
        dec_ev         = 1'b0;
        dec_evk        = '0;

        if (state_reg == ST_DECIDE)
        begin
            if (op_reg == lfu_pkg::OP_GET)
            begin
                // Touch the entry on a lookup hit
                if (match_found)
                begin
                    dec_rd            = match_entry.value;
                    wr_en             = 1'b1;
                    wr_data.use_count = count_up;
                    wr_data.stamp     = stamp_inc;
                end
            end
            else if (cap_eff != '0)
            begin
                if (match_found)
                begin
                    // Overwrite value and touch
                    wr_en             = 1'b1;
                    wr_data.value     = value_reg;
                    wr_data.use_count = count_up;
                    wr_data.stamp     = stamp_inc;
                end
                else
                begin
                    // Insert, evicting the candidate when full
                    wr_en             = 1'b1;
                    wr_data.key       = key_reg;
                    wr_data.value     = value_reg;
                    wr_data.use_count = lfu_pkg::COUNT_W'(1);
                    wr_data.stamp     = stamp_inc;
                    if ((CMP_W'(occupancy_reg) >= cap_eff) && (occupancy_reg != '0))
                    begin
                        dec_ev  = 1'b1;
                        dec_evk = victim_key;
                        wr_addr = victim_idx;
                    end
                    else
                    begin
                        wr_addr        = occupancy_reg[IDX_W-1:0];
                        occupancy_next = occupancy_reg + OCC_W'(1);
                    end
                end
            end
        end
    end

    // Sequencer, counters and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            capacity_reg  <= lfu_pkg::CAP_RESET;
            occupancy_reg <= '0;
            stamp_reg     <= '0;
            issue_cnt_reg <= '0;
            pend_reg      <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                capacity_reg <= cfg_data;
            end

            // Raise the output when a result is pushed, drop it once taken
            if ((state_reg == ST_PUSH) && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            pend_reg <= rd_en;

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_accept)
                    begin
                        issue_cnt_reg <= '0;
                        state_reg     <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (rd_en)
                    begin
                        issue_cnt_reg <= issue_cnt_reg + OCC_W'(1);
                    end
                    else if (!pend_reg)
                    begin
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE:
                begin
                    occupancy_reg <= occupancy_next;
                    if (wr_en)
                    begin
                        stamp_reg <= stamp_inc;
                    end
                    state_reg <= ST_PUSH;
                end
                ST_PUSH:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            op_reg    <= lfu_pkg::op_t'(s_tuser);
            key_reg   <= s_tdata[lfu_pkg::KEY_W-1:0];
            value_reg <= s_tdata[lfu_pkg::S_TDATA_W-1:lfu_pkg::KEY_W];
        end
        if (rd_en)
        begin
            pend_idx_reg <= issue_cnt_reg[IDX_W-1:0];
        end
        if (state_reg == ST_DECIDE)
        begin
            res_hit_reg <= dec_hit;
            res_rd_reg  <= dec_rd;
            res_ev_reg  <= dec_ev;
            res_evk_reg <= dec_evk;
        end
        if ((state_reg == ST_PUSH) && out_free)
        begin
            m_tdata_reg <= {{PAD_W{1'b0}}, res_evk_reg, res_ev_reg, res_rd_reg, res_hit_reg};
        end
    end

endmodule

// File: rtl/lfu_entry_ram.sv
// ----------------------------------------------------------------------------
// lfu_entry_ram
// Entry storage: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lfu_entry_ram #(
    parameter int ENTRIES = 16,
    parameter int IDX_W   = 4
) (
    input  logic                 clk,
    input  logic                 rd_en,
    input  logic [IDX_W-1:0]     rd_addr,
    output lfu_pkg::entry_t      rd_data,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  lfu_pkg::entry_t      wr_data
);

    lfu_pkg::entry_t mem [ENTRIES];

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read one entry, data available next cycle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/lfu_scan_unit.sv
// ----------------------------------------------------------------------------
// lfu_scan_unit
// Shared compare unit: takes one stored entry per cycle, tracks the first key
// match and the eviction candidate (lowest use count, then oldest stamp).
// ----------------------------------------------------------------------------
module lfu_scan_unit #(
    parameter int IDX_W = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          clear,
    input  logic                          entry_vld,
    input  logic [IDX_W-1:0]              entry_idx,
    input  lfu_pkg::entry_t               entry,
    input  logic [lfu_pkg::KEY_W-1:0]     key,
    output logic                          match_found,
    output logic [IDX_W-1:0]              match_idx,
    output lfu_pkg::entry_t               match_entry,
    output logic [IDX_W-1:0]              victim_idx,
    output logic [lfu_pkg::KEY_W-1:0]     victim_key
);

    logic                           match_found_reg;
    logic [IDX_W-1:0]               match_idx_reg;
    lfu_pkg::entry_t                match_entry_reg;
    logic                           best_valid_reg;
    logic [IDX_W-1:0]               best_idx_reg;
    logic [lfu_pkg::COUNT_W-1:0]    best_count_reg;
    logic [lfu_pkg::STAMP_W-1:0]    best_stamp_reg;
    logic [lfu_pkg::KEY_W-1:0]      best_key_reg;
    logic                           is_match;
    logic                           is_better;

    // Compare the incoming entry against the key and the current candidate
    always_comb
    begin
        is_match  = entry_vld && !match_found_reg && (entry.key == key);
        is_better = entry_vld &&
                    (!best_valid_reg ||
                     (entry.use_count < best_count_reg) ||
                     ((entry.use_count == best_count_reg) &&
                      (entry.stamp < best_stamp_reg)));
    end

    // Track flags, cleared at the start of each transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_found_reg <= 1'b0;
            best_valid_reg  <= 1'b0;
        end
        else if (clear)
        begin
            match_found_reg <= 1'b0;
            best_valid_reg  <= 1'b0;
        end
        else
        begin
            if (is_match)
            begin
                match_found_reg <= 1'b1;
            end
            if (is_better)
            begin
                best_valid_reg <= 1'b1;
            end
        end
    end

    // Capture matched entry and candidate payload
    always_ff @(posedge clk)
    begin
        if (is_match)
        begin
            match_idx_reg   <= entry_idx;
            match_entry_reg <= entry;
        end
        if (is_better)
        begin
            best_idx_reg   <= entry_idx;
            best_count_reg <= entry.use_count;
            best_stamp_reg <= entry.stamp;
            best_key_reg   <= entry.key;
        end
    end

    assign match_found = match_found_reg;
    assign match_idx   = match_idx_reg;
    assign match_entry = match_entry_reg;
    assign victim_idx  = best_idx_reg;
    assign victim_key  = best_key_reg;

endmodule
